// ===== hdl/nww_pkg.sv =====
// ----------------------------------------------------------------------------
// nww_pkg
// shared types and constants for the nearest waypoint window block
// ----------------------------------------------------------------------------
package nww_pkg;

  localparam int unsigned CoordW      = 32;
  localparam int unsigned WpIndexW    = 10;
  localparam int unsigned WinW        = 7;
  localparam int unsigned WindowReset = 50;
  localparam int unsigned QueueDepth  = 2;

  // request action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_QUERY
  } op_e;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] wp_x;
    logic signed [CoordW-1:0] wp_y;
    logic [WpIndexW-1:0]      wp_index;
    logic                     last;
  } rsp_t;

  typedef struct packed {
    op_e                      op;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } cmd_t;

endpackage

// ===== hdl/nww_front.sv =====
// ----------------------------------------------------------------------------
// nww_front
// accepts requests, decodes the action and queues commands for the back end
// ----------------------------------------------------------------------------
module nww_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  nww_pkg::req_t in_req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output nww_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(nww_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(nww_pkg::QueueDepth + 1);

  nww_pkg::cmd_t       entry_q [nww_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  nww_pkg::cmd_t       cmd_new;
  logic                known;
  logic                push, pop;

  always_comb begin
    cmd_new.x  = in_req_i.pos_x;
    cmd_new.y  = in_req_i.pos_y;
    cmd_new.op = nww_pkg::OP_CLEAR;
    known      = 1'b1;
    unique case (in_req_i.action)
      nww_pkg::ACT_CLEAR:  cmd_new.op = nww_pkg::OP_CLEAR;
      nww_pkg::ACT_APPEND: cmd_new.op = nww_pkg::OP_APPEND;
      nww_pkg::ACT_QUERY:  cmd_new.op = nww_pkg::OP_QUERY;
      default:             known      = 1'b0;  // unused action, dropped
    endcase
  end

  assign in_ready_o  = (cnt_q != CntW'(nww_pkg::QueueDepth));
  assign push        = in_valid_i && in_ready_o && known;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(nww_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(nww_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== hdl/nww_back.sv =====
// ----------------------------------------------------------------------------
// nww_back
// path store, nearest waypoint scan and window emission
// ----------------------------------------------------------------------------
module nww_back #(
  parameter int unsigned MAX_WAYPOINTS = 1024,
  parameter int unsigned WINDOW_MAX    = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [nww_pkg::WinW-1:0]  window_i,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  nww_pkg::cmd_t             cmd_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output nww_pkg::rsp_t             out_rsp_o
);

  localparam int unsigned AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1);
  localparam int unsigned EW = ((CW > nww_pkg::WinW) ? CW : nww_pkg::WinW) + 1;
  localparam int unsigned XW = nww_pkg::CoordW;
  localparam int unsigned DW = 2 * XW + 1;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_EMIT_RD = 2'd2;
  localparam logic [1:0] ST_EMIT_WR = 2'd3;

  logic [XW-1:0] mem_x [MAX_WAYPOINTS];
  logic [XW-1:0] mem_y [MAX_WAYPOINTS];

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       scan_q, scan_d;
  logic [CW-1:0]       emit_q, emit_d;
  logic [CW-1:0]       end_q, end_d;
  logic signed [XW-1:0] qx_q, qy_q;

  logic                wr_en;
  logic [AW-1:0]       rd_addr;
  logic [XW-1:0]       rd_x_q, rd_y_q;
  logic                issue;

  logic                v1_q, v2_q, v3_q;
  logic [AW-1:0]       idx1_q, idx2_q, idx3_q;
  logic [XW-1:0]       dx_q, dy_q;
  logic [2*XW-1:0]     sqx_q, sqy_q;
  logic [XW:0]         diff_x, diff_y;
  logic [XW-1:0]       abs_x, abs_y;
  logic [DW-1:0]       sum_sq;
  logic                better;

  logic                have_q, have_d;
  logic [DW-1:0]       best_dist_q, best_dist_d;
  logic [AW-1:0]       best_idx_q, best_idx_d;

  logic [nww_pkg::WinW-1:0] win;
  logic [EW-1:0]            end_sum;
  logic                     out_free;
  logic                     out_valid_q, out_valid_d;
  nww_pkg::rsp_t            out_q, out_d;
  logic [nww_pkg::WpIndexW+CW-1:0] idx_ext;

  // clamp the window length to the supported range
  always_comb begin
    if (window_i == '0) begin
      win = nww_pkg::WinW'(1);
    end else if (window_i > nww_pkg::WinW'(WINDOW_MAX)) begin
      win = nww_pkg::WinW'(WINDOW_MAX);
    end else begin
      win = window_i;
    end
  end

  assign issue    = (state_q == ST_SCAN) && (scan_q != count_q);
  assign rd_addr  = (state_q == ST_SCAN) ? scan_q[AW-1:0] : emit_q[AW-1:0];
  assign wr_en    = (state_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == nww_pkg::OP_APPEND)
                    && (count_q < CW'(MAX_WAYPOINTS));
  assign out_free = !out_valid_q || out_ready_i;
  assign end_sum  = EW'(best_idx_q) + EW'(win);
  assign idx_ext  = {{nww_pkg::WpIndexW{1'b0}}, emit_q};

  // path store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[count_q[AW-1:0]] <= cmd_i.x;
      mem_y[count_q[AW-1:0]] <= cmd_i.y;
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
  end

  // distance pipeline: read, absolute difference, square, compare
  assign diff_x = {qx_q[XW-1], qx_q} - {rd_x_q[XW-1], rd_x_q};
  assign diff_y = {qy_q[XW-1], qy_q} - {rd_y_q[XW-1], rd_y_q};
  assign abs_x  = diff_x[XW] ? XW'(-diff_x) : diff_x[XW-1:0];
  assign abs_y  = diff_y[XW] ? XW'(-diff_y) : diff_y[XW-1:0];
  assign sum_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign better = !have_q || (sum_sq < best_dist_q);

  always_ff @(posedge clk_i) begin
    idx1_q <= scan_q[AW-1:0];
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    dx_q   <= abs_x;
    dy_q   <= abs_y;
    sqx_q  <= {{XW{1'b0}}, dx_q} * {{XW{1'b0}}, dx_q};
    sqy_q  <= {{XW{1'b0}}, dy_q} * {{XW{1'b0}}, dy_q};
    if (state_q == ST_IDLE && cmd_valid_i) begin
      qx_q <= cmd_i.x;
      qy_q <= cmd_i.y;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    emit_d      = emit_q;
    end_d       = end_q;
    have_d      = have_q;
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cmd_ready_o = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (v3_q && better) begin
      have_d      = 1'b1;
      best_dist_d = sum_sq;
      best_idx_d  = idx3_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            nww_pkg::OP_CLEAR: count_d = '0;
            nww_pkg::OP_APPEND: begin
              if (wr_en) begin
                count_d = count_q + 1'b1;
              end
            end
            nww_pkg::OP_QUERY: begin
              if (count_q != '0) begin
                state_d = ST_SCAN;
                scan_d  = '0;
                have_d  = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          scan_d = scan_q + 1'b1;
        end else if (!v1_q && !v2_q && !v3_q) begin
          emit_d  = CW'(best_idx_q);
          end_d   = (end_sum > EW'(count_q)) ? count_q : end_sum[CW-1:0];
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.wp_x     = rd_x_q;
          out_d.wp_y     = rd_y_q;
          out_d.wp_index = idx_ext[nww_pkg::WpIndexW-1:0];
          out_d.last     = (emit_q + 1'b1 == end_q);
          emit_d         = emit_q + 1'b1;
          state_d        = (emit_q + 1'b1 == end_q) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      emit_q      <= '0;
      end_q       <= '0;
      have_q      <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      emit_q      <= emit_d;
      end_q       <= end_d;
      have_q      <= have_d;
      v1_q        <= issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_dist_q <= best_dist_d;
    best_idx_q  <= best_idx_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_WAYPOINTS))
    else $error("path count above capacity");

  a_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) |-> (!v1_q && !v2_q && !v3_q))
    else $error("distance pipeline busy outside scan");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_RD) |-> (emit_q < end_q && end_q <= count_q))
    else $error("emit index outside window");

  a_path_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_EMIT_RD || state_q == ST_EMIT_WR) |=> $stable(count_q))
    else $error("path changed during query");

endmodule

// ===== hdl/nearest_waypoint_window.sv =====
// a clear or append is queued in the front end and takes effect once the back end is idle
// a query on a path of n waypoints reads all n stored waypoints before its first waypoint goes out
// (one stored waypoint per cycle through the single read port, 4-stage distance pipeline)
// then each waypoint is read in ST_EMIT_RD and sent in ST_EMIT_WR while the output is taken
// throughput: one request at a time in the back end, queue of two in front
// reset: path emptied, window length 50; path memory contents are not cleared
// ----------------------------------------------------------------------------
// nearest_waypoint_window
// stored path with nearest waypoint search and lookahead window output
// ----------------------------------------------------------------------------
module nearest_waypoint_window #(
  parameter int unsigned MAX_WAYPOINTS = 1024,
  parameter int unsigned WINDOW_MAX    = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  nww_pkg::req_t            in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output nww_pkg::rsp_t            out_rsp_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [nww_pkg::WinW-1:0] cfg_data_i
);

  logic [nww_pkg::WinW-1:0] window_q;
  logic                     cmd_valid, cmd_ready;
  nww_pkg::cmd_t            cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= nww_pkg::WinW'(nww_pkg::WindowReset);
    end else if (cfg_valid_i) begin
      window_q <= cfg_data_i;
    end
  end

  nww_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  nww_back #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS),
    .WINDOW_MAX    (WINDOW_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .window_i    (window_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// nearest waypoint window: paths are built and queried through the request
// channel; each emitted waypoint is checked against a window worked out from a
// private copy of the path, under random idling on both sides, a long output
// hold and window settings from 0 to 127
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CoordW       = nww_pkg::CoordW;
  localparam int unsigned WinW         = nww_pkg::WinW;
  localparam int unsigned WpIndexW     = nww_pkg::WpIndexW;
  localparam int unsigned MaxWaypoints = 1024;
  localparam int unsigned WindowMax    = 64;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned HoldCycles   = 600;
  localparam int unsigned StallLimit   = 8000;
  localparam logic [1:0]  ACT_IGNORED  = 2'd3;

  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7fff_ffff;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  nww_pkg::req_t   in_req_i    = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  nww_pkg::rsp_t   out_rsp_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [WinW-1:0] cfg_data_i  = '0;

  // request stream and expected window waypoints
  nww_pkg::req_t request_q[$];
  nww_pkg::rsp_t window_q[$];

  // stimulus-side view of the path, used to aim queries
  logic signed [CoordW-1:0] plan_x[$];
  logic signed [CoordW-1:0] plan_y[$];

  // predicted block state
  logic signed [CoordW-1:0] path_x[MaxWaypoints];
  logic signed [CoordW-1:0] path_y[MaxWaypoints];
  int unsigned              path_len   = 0;
  logic [WinW-1:0]          window_len = WinW'(nww_pkg::WindowReset);

  int unsigned sender_idle_pct   = 33;
  int unsigned receiver_idle_pct = 72;
  int unsigned hold_starts       = 0;
  int unsigned hold_seen         = 0;
  int unsigned hold_left         = 0;

  int unsigned   request_count  = 0;
  int unsigned   waypoint_count = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   stall_cycles   = 0;
  nww_pkg::rsp_t want_wp;

  nearest_waypoint_window #(
    .MAX_WAYPOINTS(MaxWaypoints),
    .WINDOW_MAX   (WindowMax)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // applies one accepted request to the predicted path and queues its window
  task automatic track_request(input nww_pkg::req_t r);
    logic signed [CoordW:0] dx, dy;
    logic [CoordW-1:0]      ax, ay;
    logic [2*CoordW:0]      range_sq, best_sq;
    int unsigned            best, span, stop;
    nww_pkg::rsp_t          wp;
    case (r.action)
      nww_pkg::ACT_CLEAR: path_len = 0;
      nww_pkg::ACT_APPEND: begin
        if (path_len < MaxWaypoints) begin
          path_x[path_len] = r.pos_x;
          path_y[path_len] = r.pos_y;
          path_len++;
        end
      end
      nww_pkg::ACT_QUERY: begin
        if (path_len != 0) begin
          best    = 0;
          best_sq = '0;
          for (int unsigned i = 0; i < path_len; i++) begin
            dx = {r.pos_x[CoordW-1], r.pos_x} - {path_x[i][CoordW-1], path_x[i]};
            dy = {r.pos_y[CoordW-1], r.pos_y} - {path_y[i][CoordW-1], path_y[i]};
            ax = dx[CoordW] ? (~dx[CoordW-1:0] + 1'b1) : dx[CoordW-1:0];
            ay = dy[CoordW] ? (~dy[CoordW-1:0] + 1'b1) : dy[CoordW-1:0];
            // exact 65-bit sum of squares, no wrap
            range_sq = (2*CoordW+1)'(64'(ax) * 64'(ax)) + (2*CoordW+1)'(64'(ay) * 64'(ay));
            if (i == 0 || range_sq < best_sq) begin
              best    = i;
              best_sq = range_sq;
            end
          end
          span = (window_len == 0) ? 1 :
                 ((window_len > WindowMax) ? WindowMax : window_len);
          stop = (best + span > path_len) ? path_len : best + span;
          for (int unsigned i = best; i < stop; i++) begin
            wp.wp_x     = path_x[i];
            wp.wp_y     = path_y[i];
            wp.wp_index = WpIndexW'(i);
            wp.last     = (i + 1 == stop);
            window_q.insert(window_q.size(), wp);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_request(input logic [1:0] action,
                               input logic signed [CoordW-1:0] x, y);
    nww_pkg::req_t r;
    r.action = action;
    r.pos_x  = x;
    r.pos_y  = y;
    request_q.insert(request_q.size(), r);
    if (action == nww_pkg::ACT_CLEAR) begin
      plan_x.delete();
      plan_y.delete();
    end else if (action == nww_pkg::ACT_APPEND) begin
      plan_x.insert(plan_x.size(), x);
      plan_y.insert(plan_y.size(), y);
    end
  endtask

  function automatic logic signed [CoordW-1:0] coord_near(
    input logic signed [CoordW-1:0] c, input int unsigned spread);
    return c + $urandom_range(2 * spread) - spread;
  endfunction

  task automatic queue_nearby_query(input int unsigned spread);
    int unsigned k;
    if (plan_x.size() == 0) begin
      queue_request(nww_pkg::ACT_QUERY, $urandom(), $urandom());
    end else begin
      k = $urandom_range(plan_x.size() - 1);
      queue_request(nww_pkg::ACT_QUERY, coord_near(plan_x[k], spread),
                    coord_near(plan_y[k], spread));
    end
  endtask

  // mostly clear, append run, queries; some stray requests mixed in
  task automatic build_traffic(input int unsigned n_items);
    int unsigned              start, pts, queries, spread;
    logic signed [CoordW-1:0] cx, cy;
    @(negedge clk_i);
    start = request_q.size();
    while (request_q.size() - start < n_items) begin
      if ($urandom_range(7) == 0) begin
        queue_request(2'($urandom_range(3)), $urandom(), $urandom());
      end else begin
        queue_request(nww_pkg::ACT_CLEAR, $urandom(), $urandom());
        pts     = ($urandom_range(5) == 0) ? $urandom_range(65, 80) : $urandom_range(1, 24);
        spread  = $urandom_range(1) ? 50000 : 0;
        cx      = $urandom();
        cy      = $urandom();
        for (int unsigned i = 0; i < pts; i++) begin
          if (i != 0 && $urandom_range(9) == 0) begin
            // repeated point gives distance ties
            queue_request(nww_pkg::ACT_APPEND, plan_x[$], plan_y[$]);
          end else if (spread == 0) begin
            queue_request(nww_pkg::ACT_APPEND, $urandom(), $urandom());
          end else begin
            queue_request(nww_pkg::ACT_APPEND, coord_near(cx, spread), coord_near(cy, spread));
          end
        end
        queries = $urandom_range(1, 4);
        for (int unsigned i = 0; i < queries; i++) begin
          if ($urandom_range(4) == 0) queue_request(nww_pkg::ACT_QUERY, $urandom(), $urandom());
          else queue_nearby_query(200);
          if ($urandom_range(4) == 0) begin
            queue_request(nww_pkg::ACT_APPEND, coord_near(cx, 50000), coord_near(cy, 50000));
          end
        end
      end
    end
  endtask

  task automatic settle();
    while (request_q.size() != 0 || in_valid_i || window_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WinW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idle(input int unsigned sender_pct, receiver_pct);
    @(negedge clk_i);
    sender_idle_pct   = sender_pct;
    receiver_idle_pct = receiver_pct;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        in_req_i   <= request_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_seen != hold_starts) begin
      hold_seen   <= hold_starts;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) window_len = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        track_request(in_req_i);
        request_count++;
      end
      if (out_valid_o && out_ready_i) begin
        waypoint_count++;
        if (window_q.size() == 0) begin
          $error("waypoint index %0d emitted with none predicted", out_rsp_o.wp_index);
          mismatch_count++;
        end else begin
          want_wp = window_q.pop_front();
          if (out_rsp_o.wp_x !== want_wp.wp_x) begin
            $error("wp_x: expected %0d, got %0d", want_wp.wp_x, out_rsp_o.wp_x);
            mismatch_count++;
          end
          if (out_rsp_o.wp_y !== want_wp.wp_y) begin
            $error("wp_y: expected %0d, got %0d", want_wp.wp_y, out_rsp_o.wp_y);
            mismatch_count++;
          end
          if (out_rsp_o.wp_index !== want_wp.wp_index) begin
            $error("wp_index: expected %0d, got %0d", want_wp.wp_index, out_rsp_o.wp_index);
            mismatch_count++;
          end
          if (out_rsp_o.last !== want_wp.last) begin
            $error("last: expected %0d, got %0d", want_wp.last, out_rsp_o.last);
            mismatch_count++;
          end
        end
      end
    end
  end

  // no-progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("timeout after %0d cycles without a handshake", stall_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : main
    logic signed [CoordW-1:0] cx, cy;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset window length
    @(negedge clk_i);
    queue_request(nww_pkg::ACT_QUERY, 0, 0);                  // empty path
    queue_request(ACT_IGNORED, -1, -1);
    queue_request(nww_pkg::ACT_CLEAR, 0, 0);
    // first point is farther but its squared distance only differs above bit 63
    queue_request(nww_pkg::ACT_APPEND, CoordMin, 0);
    queue_request(nww_pkg::ACT_APPEND, CoordMax - 32'sd1048576, 32'sd131072);
    queue_request(nww_pkg::ACT_QUERY, CoordMax, 32'sd131072);
    queue_request(nww_pkg::ACT_CLEAR, CoordMax, CoordMin);
    queue_request(nww_pkg::ACT_APPEND, CoordMin, CoordMin);
    queue_request(nww_pkg::ACT_APPEND, CoordMax, CoordMax);
    queue_request(nww_pkg::ACT_APPEND, 5, 5);
    queue_request(nww_pkg::ACT_APPEND, -7, 3);
    queue_request(nww_pkg::ACT_APPEND, 5, 5);
    queue_request(ACT_IGNORED, CoordMax, CoordMax);           // must not append
    queue_request(nww_pkg::ACT_QUERY, CoordMax, CoordMax);
    queue_request(nww_pkg::ACT_QUERY, CoordMin, CoordMin);
    queue_request(nww_pkg::ACT_QUERY, 6, 6);                  // tie, lower index wins
    queue_request(nww_pkg::ACT_QUERY, CoordMin, CoordMax);    // tie at the far corners
    queue_request(nww_pkg::ACT_QUERY, -7, 3);
    queue_request(nww_pkg::ACT_APPEND, 0, CoordMin);
    queue_request(nww_pkg::ACT_QUERY, CoordMax, CoordMin);
    settle();

    write_window(7'd1);
    build_traffic(12);
    settle();
    write_window(7'd0);
    build_traffic(12);
    settle();

    // output held long enough for the request side to back up
    set_idle(72, 33);
    write_window(7'd64);
    @(negedge clk_i);
    queue_request(nww_pkg::ACT_CLEAR, 0, 0);
    cx = $urandom();
    cy = $urandom();
    for (int i = 0; i < 70; i++) begin
      queue_request(nww_pkg::ACT_APPEND, coord_near(cx, 20000), coord_near(cy, 20000));
    end
    for (int i = 0; i < 6; i++) queue_nearby_query(100);
    hold_starts++;
    settle();
    write_window(7'd127);
    build_traffic(12);
    settle();

    set_idle(0, 0);
    write_window(7'd65);
    build_traffic(12);
    settle();

    write_window(7'($urandom_range(2, 63)));
    build_traffic(12);
    settle();

    $display("%0d requests accepted, %0d window waypoints checked", request_count,
             waypoint_count);
    $display("window lengths 0 to 127, long output hold, distance ties and extreme coordinates");
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
